[sv/assert_macros.svh]
// Assertion macros shared by the cipher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk_i edge, off while rst_ni is low.
`define CSCBC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cscbc check failed");

// Condition that must never be true.
`define CSCBC_NEVER(name, cond) `CSCBC_ASSERT(name, !(cond))

`endif

[sv/cscbc_pkg.sv]
// Shared types, tables and round functions of the CBC block cipher.
package cscbc_pkg;

  localparam int unsigned NumSubkeys = 9;
  localparam int unsigned NumRounds  = 8;

  typedef enum logic [1:0] {
    CFG_KEY_FIRST   = 2'd0,
    CFG_KEY_SECOND  = 2'd1,
    CFG_INIT_VECTOR = 2'd2
  } cfg_reg_e;

  typedef logic [NumSubkeys-1:0][63:0] rkeys_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ks_stat_t;

  localparam logic [7:0] PERM [256] = '{
    8'h29,8'h0d,8'h61,8'h40,8'h9c,8'heb,8'h9e,8'h8f,8'h1f,8'h85,8'h5f,8'h58,8'h5b,8'h01,8'h39,8'h86,
    8'h97,8'h2e,8'hd7,8'hd6,8'h35,8'hae,8'h17,8'h16,8'h21,8'hb6,8'h69,8'h4e,8'ha5,8'h72,8'h87,8'h08,
    8'h3c,8'h18,8'he6,8'he7,8'hfa,8'had,8'hb8,8'h89,8'hb7,8'h00,8'hf7,8'h6f,8'h73,8'h84,8'h11,8'h63,
    8'h3f,8'h96,8'h7f,8'h6e,8'hbf,8'h14,8'h9d,8'hac,8'ha4,8'h0e,8'h7e,8'hf6,8'h20,8'h4a,8'h62,8'h30,
    8'h03,8'hc5,8'h4b,8'h5a,8'h46,8'ha3,8'h44,8'h65,8'h7d,8'h4d,8'h3d,8'h42,8'h79,8'h49,8'h1b,8'h5c,
    8'hf5,8'h6c,8'hb5,8'h94,8'h54,8'hff,8'h56,8'h57,8'h0b,8'hf4,8'h43,8'h0c,8'h4f,8'h70,8'h6d,8'h0a,
    8'he4,8'h02,8'h3e,8'h2f,8'ha2,8'h47,8'he0,8'hc1,8'hd5,8'h1a,8'h95,8'ha7,8'h51,8'h5e,8'h33,8'h2b,
    8'h5d,8'hd4,8'h1d,8'h2c,8'hee,8'h75,8'hec,8'hdd,8'h7c,8'h4c,8'ha6,8'hb4,8'h78,8'h48,8'h3a,8'h32,
    8'h98,8'haf,8'hc0,8'he1,8'h2d,8'h09,8'h0f,8'h1e,8'hb9,8'h27,8'h8a,8'he9,8'hbd,8'he3,8'h9f,8'h07,
    8'hb1,8'hea,8'h92,8'h93,8'h53,8'h6a,8'h31,8'h10,8'h80,8'hf2,8'hd8,8'h9b,8'h04,8'h36,8'h06,8'h8e,
    8'hbe,8'ha9,8'h64,8'h45,8'h38,8'h1c,8'h7a,8'h6b,8'hf3,8'ha1,8'hf0,8'hcd,8'h37,8'h25,8'h15,8'h81,
    8'hfb,8'h90,8'he8,8'hd9,8'h7b,8'h52,8'h19,8'h28,8'h26,8'h88,8'hfc,8'hd1,8'he2,8'h8c,8'ha0,8'h34,
    8'h82,8'h67,8'hda,8'hcb,8'hc7,8'h41,8'he5,8'hc4,8'hc8,8'hef,8'hdb,8'hc3,8'hcc,8'hab,8'hce,8'hed,
    8'hd0,8'hbb,8'hd3,8'hd2,8'h71,8'h68,8'h13,8'h12,8'h9a,8'hb3,8'hc2,8'hca,8'hde,8'h77,8'hdc,8'hdf,
    8'h66,8'h83,8'hbc,8'h8d,8'h60,8'hc6,8'h22,8'h23,8'hb2,8'h8b,8'h91,8'h05,8'h76,8'hcf,8'h74,8'hc9,
    8'haa,8'hf1,8'h99,8'ha8,8'h59,8'h50,8'h3b,8'h2a,8'hfe,8'hf9,8'h24,8'hb0,8'hba,8'hfd,8'hf8,8'h55
  };

  // c and c' mixing constants, one pair per constant step
  localparam logic [7:0] MIXC [16] = '{
    8'hb7,8'he1,8'h51,8'h62,8'h8a,8'hed,8'h2a,8'h6a,
    8'hbf,8'h71,8'h58,8'h80,8'h9c,8'hf4,8'hf3,8'hc7
  };

  localparam logic [2:0] PAIR_L [8] = '{3'd0,3'd4,3'd1,3'd5,3'd0,3'd1,3'd2,3'd3};
  localparam logic [2:0] PAIR_R [8] = '{3'd2,3'd6,3'd3,3'd7,3'd4,3'd5,3'd6,3'd7};

  localparam logic [7:0] MASK_EVEN = 8'h55;
  localparam logic [7:0] MASK_ODD  = 8'hAA;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return PERM[x];
  endfunction

  function automatic logic [7:0] rotl1(input logic [7:0] x);
    return {x[6:0], x[7]};
  endfunction

  // table row XORed into the previous subkey at schedule step s
  function automatic logic [63:0] key_row(input logic [3:0] s);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[63-8*i -: 8] = PERM[{1'b0, s, 3'(i)}];
    end
    return r;
  endfunction

  // forward mixing step, returns {left, right}
  function automatic logic [15:0] mix_fwd(input logic [7:0] l, input logic [7:0] r,
                                          input logic [7:0] cl, input logic [7:0] cr);
    logic [7:0] x;
    logic [7:0] rx;
    logic [7:0] y;
    x  = l ^ cl;
    rx = rotl1(x);
    y  = r ^ cr;
    return {sbox((rx & MASK_EVEN) ^ x ^ y), sbox(rx ^ y)};
  endfunction

  // inverse mixing step, returns {left, right}
  function automatic logic [15:0] mix_inv(input logic [7:0] l, input logic [7:0] r,
                                          input logic [7:0] cl, input logic [7:0] cr);
    logic [7:0] pr;
    logic [7:0] d;
    logic [7:0] xl;
    pr = sbox(r);
    d  = sbox(l) ^ pr;
    xl = (rotl1(d) & MASK_ODD) ^ d;
    return {xl ^ cl, rotl1(xl) ^ pr ^ cr};
  endfunction

  function automatic logic [63:0] fwd_round(input logic [63:0] w, input logic [63:0] k);
    logic [7:0] m [8];
    logic [7:0] kb [8];
    logic [63:0] res;
    for (int i = 0; i < 8; i++) begin
      m[i]  = w[63-8*i -: 8];
      kb[i] = k[63-8*i -: 8];
    end
    for (int i = 0; i < 4; i++) begin
      {m[2*i], m[2*i+1]} = mix_fwd(m[2*i], m[2*i+1], kb[2*i], kb[2*i+1]);
    end
    for (int i = 0; i < 8; i++) begin
      {m[PAIR_L[i]], m[PAIR_R[i]]} = mix_fwd(m[PAIR_L[i]], m[PAIR_R[i]],
                                             MIXC[4'(2*i)], MIXC[4'(2*i+1)]);
    end
    res = '0;
    for (int i = 0; i < 8; i++) begin
      res[63-8*i -: 8] = m[i];
    end
    return res;
  endfunction

  function automatic logic [63:0] inv_round(input logic [63:0] w, input logic [63:0] k);
    logic [7:0] m [8];
    logic [7:0] kb [8];
    logic [63:0] res;
    for (int i = 0; i < 8; i++) begin
      m[i]  = w[63-8*i -: 8];
      kb[i] = k[63-8*i -: 8];
    end
    for (int i = 7; i >= 0; i--) begin
      {m[PAIR_L[i]], m[PAIR_R[i]]} = mix_inv(m[PAIR_L[i]], m[PAIR_R[i]],
                                             MIXC[4'(2*i)], MIXC[4'(2*i+1)]);
    end
    for (int i = 0; i < 4; i++) begin
      {m[2*i], m[2*i+1]} = mix_inv(m[2*i], m[2*i+1], kb[2*i], kb[2*i+1]);
    end
    res = '0;
    for (int i = 0; i < 8; i++) begin
      res[63-8*i -: 8] = m[i];
    end
    return res;
  endfunction

endpackage

[sv/cscbc_key_sched.sv]
// Subkey generator: one subkey per cycle into the round key registers.
module cscbc_key_sched (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [63:0]         key_first_i,
  input  logic [63:0]         key_second_i,
  output cscbc_pkg::ks_stat_t stat_o,
  output cscbc_pkg::rkeys_t   round_keys_o
);

  logic [3:0]        step_q;
  logic              busy_q;
  logic [63:0]       prev1_q;
  logic [63:0]       prev2_q;
  cscbc_pkg::rkeys_t rk_q;
  logic [63:0]       next_key;
  logic              last_step;

  assign last_step = (step_q == 4'(cscbc_pkg::NumSubkeys - 1));

  // byte permutation after the table row, then 8x8 bit transpose
  always_comb begin
    logic [63:0] row;
    logic [7:0]  p [8];
    logic [7:0]  t [8];
    row = cscbc_pkg::key_row(step_q);
    for (int i = 0; i < 8; i++) begin
      p[i] = cscbc_pkg::sbox(prev1_q[63-8*i -: 8] ^ row[63-8*i -: 8]);
    end
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        t[i][7-j] = p[j][7-i];
      end
    end
    next_key = prev2_q;
    for (int i = 0; i < 8; i++) begin
      next_key[63-8*i -: 8] = prev2_q[63-8*i -: 8] ^ t[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      busy_q <= !last_step;
      step_q <= step_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prev2_q <= key_second_i;
      prev1_q <= key_first_i;
    end else if (busy_q) begin
      rk_q[step_q] <= next_key;
      prev2_q      <= prev1_q;
      prev1_q      <= next_key;
    end
  end

  assign stat_o.busy   = busy_q;
  assign stat_o.done   = busy_q && last_step;
  assign round_keys_o  = rk_q;

endmodule

[sv/cscbc_round.sv]
// One full cipher round, forward or inverse, shared over all eight rounds.
module cscbc_round (
  input  logic        decrypt_i,
  input  logic [63:0] state_i,
  input  logic [63:0] key_i,
  output logic [63:0] state_o
);

  always_comb begin
    if (decrypt_i) begin
      state_o = cscbc_pkg::inv_round(state_i, key_i);
    end else begin
      state_o = cscbc_pkg::fwd_round(state_i, key_i);
    end
  end

endmodule

[sv/block_cipher_cbc_64.sv]
// Top level: CS-Cipher 64-bit block engine in CBC mode.
//
//   channel  direction  handshake                 payload
//   cfg      in         cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
//   in       in         in_valid_i/in_ready_o     operation_i, new_chain_i, data_block_i
//   out      out        out_valid_o/out_ready_i   result_block_o
//
// Timing: one round per clock on a shared round unit, the last round waiting
// until the result register is free; a new block is taken only after the last
// one has left the round unit. The first block after reset or a key write
// first runs the key schedule (one subkey per clock).
// Reset clears keys, IV and chain value to zero and marks the subkeys stale.
// A result that is not taken holds the last round; the input stays closed
// until the result register is free again. Config writes are always taken.
module block_cipher_cbc_64 (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // input blocks
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic        new_chain_i,
  input  logic [63:0] data_block_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_block_o
);

  `include "assert_macros.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEYS,
    ST_ROUND
  } state_e;

  state_e state_q;

  // configuration registers
  logic [63:0] key_first_q;
  logic [63:0] key_second_q;
  logic [63:0] iv_q;
  logic        keys_valid_q;
  logic        key_wr;

  // block datapath
  logic [63:0] chain_q;
  logic [63:0] data_q;     // working state between rounds
  logic [63:0] blk_q;      // input block, next chain value when decrypting
  logic        dec_q;
  logic [2:0]  rnd_q;

  logic        out_valid_q;
  logic [63:0] out_q;

  // key schedule
  logic                ks_start;
  cscbc_pkg::ks_stat_t ks_stat;
  cscbc_pkg::rkeys_t   rkeys;

  // round unit
  logic [2:0]  key_sel;
  logic [63:0] round_in;
  logic [63:0] round_out;
  logic [63:0] last_key;
  logic [63:0] result;
  logic [63:0] chain_sel;
  logic        in_xfer;
  logic        last_rnd;
  logic        out_free;
  logic        res_load;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign ks_start    = in_xfer && !keys_valid_q;
  assign chain_sel   = new_chain_i ? iv_q : chain_q;
  assign key_wr      = cfg_valid_i && cfg_ready_o &&
                       (cfg_index_i inside {cscbc_pkg::CFG_KEY_FIRST,
                                            cscbc_pkg::CFG_KEY_SECOND});

  assign last_key = rkeys[cscbc_pkg::NumSubkeys-1];
  assign last_rnd = (rnd_q == 3'(cscbc_pkg::NumRounds - 1));
  assign out_free = !out_valid_q || out_ready_i;
  assign res_load = (state_q == ST_ROUND) && last_rnd && out_free;

  // decryption walks the subkeys backwards and whitens before the first round
  assign key_sel  = dec_q ? ~rnd_q : rnd_q;
  assign round_in = (dec_q && (rnd_q == '0)) ? (data_q ^ last_key) : data_q;
  assign result   = dec_q ? (round_out ^ chain_q) : (round_out ^ last_key);

  cscbc_key_sched u_key_sched (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (ks_start),
    .key_first_i  (key_first_q),
    .key_second_i (key_second_q),
    .stat_o       (ks_stat),
    .round_keys_o (rkeys)
  );

  cscbc_round u_round (
    .decrypt_i (dec_q),
    .state_i   (round_in),
    .key_i     (rkeys[{1'b0, key_sel}]),
    .state_o   (round_out)
  );

  // configuration writes; a key write marks the subkeys stale
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_first_q  <= '0;
      key_second_q <= '0;
      iv_q         <= '0;
      keys_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          cscbc_pkg::CFG_KEY_FIRST: begin
            key_first_q  <= cfg_data_i;
          end
          cscbc_pkg::CFG_KEY_SECOND: begin
            key_second_q <= cfg_data_i;
          end
          cscbc_pkg::CFG_INIT_VECTOR: begin
            iv_q <= cfg_data_i;
          end
          default: begin
          end
        endcase
      end
      if (key_wr) begin
        keys_valid_q <= 1'b0;
      end else if (ks_stat.done) begin
        keys_valid_q <= 1'b1;
      end
    end
  end

  // sequencer, chain value and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rnd_q       <= '0;
      chain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            chain_q <= chain_sel;
            rnd_q   <= '0;
            state_q <= keys_valid_q ? ST_ROUND : ST_KEYS;
          end
        end
        ST_KEYS: begin
          if (ks_stat.done) begin
            state_q <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          if (!last_rnd) begin
            rnd_q <= rnd_q + 3'd1;
          end else if (out_free) begin
            chain_q <= dec_q ? blk_q : result;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      data_q <= operation_i ? data_block_i : (data_block_i ^ chain_sel);
      blk_q  <= data_block_i;
      dec_q  <= operation_i;
    end else if (state_q == ST_ROUND && !last_rnd) begin
      data_q <= round_out;
    end
    if (res_load) begin
      out_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_block_o = out_q;

  `CSCBC_ASSERT(a_round_keys_valid, (state_q == ST_ROUND) |-> keys_valid_q)
  `CSCBC_ASSERT(a_keys_to_round, ks_stat.done |=> (state_q == ST_ROUND))
  `CSCBC_ASSERT(a_chain_held_in_keys, (state_q == ST_KEYS) |=> $stable(chain_q))
  `CSCBC_NEVER(a_sched_idle_in_round, ks_stat.busy && (state_q == ST_ROUND))

endmodule
